// ===== src/acc_alu_pkg.sv =====
// Shared operation codes and field widths for the accumulator ALU.
`timescale 1ns / 1ps

package acc_alu_pkg;

  localparam int KIND_W    = 5;
  localparam int OPERAND_W = 32;
  localparam int ACC_OUT_W = 32;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t OP_SETACC  = 5'd0;
  localparam kind_t OP_SETCOND = 5'd1;
  localparam kind_t OP_ADD     = 5'd2;
  localparam kind_t OP_SUB     = 5'd3;
  localparam kind_t OP_RSUB    = 5'd4;
  localparam kind_t OP_MUL     = 5'd5;
  localparam kind_t OP_DIV     = 5'd6;
  localparam kind_t OP_RDIV    = 5'd7;
  localparam kind_t OP_MOD     = 5'd8;
  localparam kind_t OP_RMOD    = 5'd9;
  localparam kind_t OP_AND     = 5'd10;
  localparam kind_t OP_OR      = 5'd11;
  localparam kind_t OP_XOR     = 5'd12;
  localparam kind_t OP_GT      = 5'd13;
  localparam kind_t OP_EQ      = 5'd14;
  localparam kind_t OP_LT      = 5'd15;
  localparam kind_t OP_GE      = 5'd16;
  localparam kind_t OP_LE      = 5'd17;
  localparam kind_t OP_NE      = 5'd18;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_ABORT = 1'b1;

endpackage

// ===== src/accumulator_alu_with_abort_core.sv =====
// Accumulator ALU with abort: sequencer, shared adder, shift-add multiply, restoring divide.
`timescale 1ns / 1ps
// Sequence: simple ops (set, add, sub, logic, compares) go from S_IDLE to S_FIN and load
//   the result register at commit; mul, div and mod first iterate in S_RUN, one bit per
//   cycle through the shared DATA_WIDTH+1 bit adder, then commit from S_FIN.
// One instruction at a time: req_stall stays high from acceptance until commit,
//   and commit waits while a pending result beat is stalled.
// Reset (rst, synchronous): accumulator and flag cleared, sequencer idle, no result pending.

module accumulator_alu_with_abort_core #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // request channel
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  logic [acc_alu_pkg::KIND_W-1:0]       kind,
  input  logic [acc_alu_pkg::OPERAND_W-1:0]    operand_value,
  // result channel
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output logic                                 status,
  output logic [acc_alu_pkg::ACC_OUT_W-1:0]    acc_value,
  output logic                                 cond_flag
);
  import acc_alu_pkg::*;

  localparam int DW    = DATA_WIDTH;
  localparam int CNT_W = $clog2(DATA_WIDTH);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;  // mul / div iterations
  localparam logic [1:0] S_FIN  = 2'd2;  // commit and load the result register

  logic [1:0]       state;
  logic [CNT_W-1:0] cnt;

  // architectural state
  logic [DW-1:0] acc;
  logic          cond;

  // latched instruction
  kind_t         kind_r;
  logic [DW-1:0] opv;

  // iteration registers
  //   mul: w_hi = partial product, w_lo = multiplier (shifts right), w_op = multiplicand (<<)
  //   div: w_hi = remainder, w_lo = dividend out / quotient in, w_op = divisor
  logic [DW-1:0] w_hi;
  logic [DW-1:0] w_lo;
  logic [DW-1:0] w_op;

  logic [DW-1:0] v_in;
  logic          req_beat;
  logic          rsp_free;
  logic          commit;
  logic          iter_op;
  logic          div_op;

  // the one shared adder / subtractor, DW+1 bit operands, carry out on top
  logic [DW:0]   add_x;
  logic [DW:0]   add_y;
  logic          add_sub;
  logic [DW+1:0] add_res;
  logic          no_borrow;

  // commit values
  logic [DW-1:0] acc_next;
  logic          cond_next;
  logic          abort_next;
  logic          eq;
  logic          nz;

  assign v_in     = DW'(operand_value);   // operand taken modulo 2^DATA_WIDTH
  assign req_stall = (state != S_IDLE);
  assign req_beat = req_valid && !req_stall;
  assign rsp_free = !rsp_valid || !rsp_stall;
  assign commit   = (state == S_FIN) && rsp_free;

  assign iter_op = (kind inside {OP_MUL, OP_DIV, OP_RDIV, OP_MOD, OP_RMOD});
  assign div_op  = (kind_r inside {OP_DIV, OP_RDIV, OP_MOD, OP_RMOD});

  // adder operand selection
  always_comb begin
    add_x   = {1'b0, acc};
    add_y   = {1'b0, opv};
    add_sub = 1'b1;
    if (state == S_RUN) begin
      if (kind_r == OP_MUL) begin
        add_x   = {1'b0, w_hi};
        add_y   = {1'b0, w_op};
        add_sub = 1'b0;
      end else begin
        add_x   = {w_hi, w_lo[DW-1]};   // shift next dividend bit into the remainder
        add_y   = {1'b0, w_op};
      end
    end else begin
      case (kind_r)
        OP_ADD: add_sub = 1'b0;
        OP_RSUB: begin
          add_x = {1'b0, opv};
          add_y = {1'b0, acc};
        end
        default: ;
      endcase
    end
  end

  assign add_res   = {1'b0, add_x} + {1'b0, add_sub ? ~add_y : add_y} + (DW+2)'(add_sub);
  assign no_borrow = add_res[DW+1];

  assign eq = (acc == opv);
  assign nz = |opv;

  // result of the instruction, evaluated in S_FIN
  always_comb begin
    acc_next   = acc;
    cond_next  = cond;
    abort_next = STATUS_OK;
    case (kind_r)
      OP_SETACC:  acc_next  = opv;
      OP_SETCOND: cond_next = nz;
      OP_ADD:     acc_next  = add_res[DW-1:0];
      OP_SUB, OP_RSUB: begin
        if (no_borrow) acc_next = add_res[DW-1:0];
        else abort_next = STATUS_ABORT;
      end
      OP_MUL:     acc_next = w_hi;
      OP_DIV, OP_RDIV, OP_MOD, OP_RMOD: begin
        if (w_op == '0) abort_next = STATUS_ABORT;
        else if (kind_r inside {OP_DIV, OP_RDIV}) acc_next = w_lo;
        else acc_next = w_hi;
      end
      OP_AND:     cond_next = cond & nz;
      OP_OR:      cond_next = cond | nz;
      OP_XOR:     cond_next = cond ^ nz;
      OP_GT:      cond_next = no_borrow && !eq;
      OP_EQ:      cond_next = eq;
      OP_LT:      cond_next = !no_borrow;
      OP_GE:      cond_next = no_borrow;
      OP_LE:      cond_next = !no_borrow || eq;
      OP_NE:      cond_next = !eq;
      default: ;  // unused codes: no-op
    endcase
  end

  // sequencer and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      acc       <= '0;
      cond      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // a new beat may replace the one taken at this edge
      if (commit) rsp_valid <= 1'b1;
      else if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_beat) state <= iter_op ? S_RUN : S_FIN;
        end
        S_RUN: begin
          if (cnt == CNT_W'(DATA_WIDTH - 1)) begin
            cnt   <= '0;
            state <= S_FIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_FIN: begin
          if (commit) begin
            if (abort_next == STATUS_OK) begin
              acc  <= acc_next;
              cond <= cond_next;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload: instruction latch, iteration registers, result register
  always_ff @(posedge clk) begin
    if (req_beat) begin
      kind_r <= kind;
      opv    <= v_in;
      w_hi   <= '0;
      case (kind)
        OP_MUL, OP_RDIV, OP_RMOD: begin
          w_lo <= v_in;
          w_op <= acc;
        end
        default: begin
          w_lo <= acc;
          w_op <= v_in;
        end
      endcase
    end else if (state == S_RUN) begin
      if (kind_r == OP_MUL) begin
        if (w_lo[0]) w_hi <= add_res[DW-1:0];
        w_lo <= w_lo >> 1;
        w_op <= w_op << 1;
      end else if (div_op) begin
        if (no_borrow) w_hi <= add_res[DW-1:0];
        else w_hi <= {w_hi[DW-2:0], w_lo[DW-1]};
        w_lo <= {w_lo[DW-2:0], no_borrow};
      end
    end
    if (commit) begin
      status    <= abort_next;
      acc_value <= ACC_OUT_W'((abort_next == STATUS_OK) ? acc_next : acc);
      cond_flag <= (abort_next == STATUS_OK) ? cond_next : cond;
    end
  end

  // checks
  a_abort_keeps_state: assert property (@(posedge clk) disable iff (rst)
    commit && (abort_next == STATUS_ABORT) |=> (acc == $past(acc)) && (cond == $past(cond)))
    else $error("abort changed accumulator state");

  a_rsp_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_FIN)
    else $error("result beat raised outside commit");

  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    state != S_RUN |-> cnt == '0)
    else $error("iteration counter not cleared");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(acc_value) && $stable(status))
    else $error("pending result beat overwritten");

endmodule

// ===== dv/acc_alu_checker.sv =====
// Scoreboard for the accumulator ALU: predicts each result beat and compares it.
`timescale 1ns / 1ps

module acc_alu_checker
  import acc_alu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_stall,
  input  logic [KIND_W-1:0]    kind,
  input  logic [OPERAND_W-1:0] operand_value,
  input  logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  logic                 status,
  input  logic [ACC_OUT_W-1:0] acc_value,
  input  logic                 cond_flag,
  output int                   fail_count,
  output int                   results_owed
);

  typedef struct packed {
    logic                 st;
    logic [ACC_OUT_W-1:0] acc;
    logic                 cond;
  } alu_beat_t;

  alu_beat_t            owed_beats[$];
  logic [OPERAND_W-1:0] acc_q;
  logic                 cond_q;
  int                   fails;

  // One instruction against the given state; returns status and the state after it.
  function automatic alu_beat_t alu_exec(kind_t op, logic [OPERAND_W-1:0] v,
                                         logic [OPERAND_W-1:0] acc, logic cond);
    alu_beat_t            r;
    logic [OPERAND_W-1:0] a;
    logic                 c;
    logic                 nz;
    logic                 bad;
    a   = acc;
    c   = cond;
    nz  = (v != '0);
    bad = 1'b0;
    case (op)
      OP_SETACC:  a = v;
      OP_SETCOND: c = nz;
      OP_ADD:     a = acc + v;
      OP_SUB: begin
        if (v > acc) bad = 1'b1;
        else a = acc - v;
      end
      OP_RSUB: begin
        if (acc > v) bad = 1'b1;
        else a = v - acc;
      end
      OP_MUL:     a = acc * v;
      OP_DIV: begin
        if (v == '0) bad = 1'b1;
        else a = acc / v;
      end
      OP_RDIV: begin
        if (acc == '0) bad = 1'b1;
        else a = v / acc;
      end
      OP_MOD: begin
        if (v == '0) bad = 1'b1;
        else a = acc % v;
      end
      OP_RMOD: begin
        if (acc == '0) bad = 1'b1;
        else a = v % acc;
      end
      OP_AND:     c = cond & nz;
      OP_OR:      c = cond | nz;
      OP_XOR:     c = cond ^ nz;
      OP_GT:      c = (acc > v);
      OP_EQ:      c = (acc == v);
      OP_LT:      c = (acc < v);
      OP_GE:      c = (acc >= v);
      OP_LE:      c = (acc <= v);
      OP_NE:      c = (acc != v);
      default: ;
    endcase
    r.st   = bad ? STATUS_ABORT : STATUS_OK;
    r.acc  = bad ? acc : a;
    r.cond = bad ? cond : c;
    return r;
  endfunction

  always @(posedge clk) begin
    alu_beat_t want;
    if (rst) begin
      acc_q  = '0;
      cond_q = 1'b0;
      owed_beats.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (owed_beats.size() == 0) begin
          $error("result beat with none owed: status %0b acc_value %h cond_flag %0b",
                 status, acc_value, cond_flag);
          fails++;
        end else begin
          want = owed_beats.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0b, got %0b", want.st, status);
            fails++;
          end
          if (acc_value !== want.acc) begin
            $error("acc_value: expected %h, got %h", want.acc, acc_value);
            fails++;
          end
          if (cond_flag !== want.cond) begin
            $error("cond_flag: expected %0b, got %0b", want.cond, cond_flag);
            fails++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        want   = alu_exec(kind_t'(kind), operand_value, acc_q, cond_q);
        acc_q  = want.acc;
        cond_q = want.cond;
        owed_beats.push_back(want);
      end
    end
    fail_count   <= fails;
    results_owed <= owed_beats.size();
  end

endmodule

// ===== dv/tb_accumulator_alu_with_abort_core.sv =====
// Top-level bench for the accumulator ALU: stimulus, back-pressure, timeout and verdict.
`timescale 1ns / 1ps

module tb_accumulator_alu_with_abort_core;
  import acc_alu_pkg::*;

  // the unused kinds are no-ops; bounds of that range
  localparam kind_t KIND_SPARE_LO = 5'd19;
  localparam kind_t KIND_SPARE_HI = 5'd31;

  localparam int RANDOM_BEATS = 800;
  localparam int PAUSE_AT     = 300;   // sender drains the block here
  localparam int QUIET_FROM   = 420;   // no idling on either side in this window
  localparam int QUIET_TO     = 540;
  localparam int HOLD_AFTER   = 150;   // result beats taken before the long hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;    // settle time after the final drain, beyond one instruction's worst case
  localparam int CYCLE_LIMIT  = 200000;

  logic                 clk;
  logic                 rst;
  logic                 req_valid;
  logic                 req_stall;
  logic [KIND_W-1:0]    kind;
  logic [OPERAND_W-1:0] operand_value;
  logic                 rsp_valid;
  logic                 rsp_stall;
  logic                 status;
  logic [ACC_OUT_W-1:0] acc_value;
  logic                 cond_flag;

  int   fail_count;
  int   results_owed;
  logic quiet;
  int   cyc;

  accumulator_alu_with_abort_core dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .kind          (kind),
    .operand_value (operand_value),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .acc_value     (acc_value),
    .cond_flag     (cond_flag)
  );

  acc_alu_checker scoreboard (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .kind          (kind),
    .operand_value (operand_value),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .acc_value     (acc_value),
    .cond_flag     (cond_flag),
    .fail_count    (fail_count),
    .results_owed  (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one instruction beat, after a random idle gap, and hold it until taken.
  // All updates land at the clock edge; stall is read before the block's own
  // updates of that edge take effect.
  task automatic offer_instr(input kind_t k, input logic [OPERAND_W-1:0] v);
    while (!quiet && $urandom_range(0, 99) < 18) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid     <= 1'b1;
    kind          <= k;
    operand_value <= v;
    do @(posedge clk); while (req_stall);
  endtask

  // Lower valid and wait for every owed result beat. One edge first, so a beat
  // accepted at the last edge is already counted as owed.
  task automatic drain_block();
    req_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  // Operand mix: zero, one and small values give equal compares, exact divides
  // and reachable underflows; near-all-ones gives wrap on add and mul.
  function automatic logic [OPERAND_W-1:0] pick_operand();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    else if (r < 20) return 32'd1;
    else if (r < 45) return OPERAND_W'($urandom_range(0, 15));
    else if (r < 55) return 32'hFFFF_FFFF - OPERAND_W'($urandom_range(0, 3));
    else return $urandom;
  endfunction

  function automatic kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return kind_t'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    else if (r < 20) return OP_SETACC;   // reload keeps the accumulator interesting
    else return kind_t'($urandom_range(OP_SETACC, OP_NE));
  endfunction

  // Receiver: random stalls, a quiet window, and one long hold-off counted here
  // while the sender keeps offering, so the block backs up and stalls requests.
  initial begin
    int beats_taken;
    int hold_left;
    bit hold_done;
    beats_taken = 0;
    hold_left   = 0;
    hold_done   = 1'b0;
    rsp_stall  <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) beats_taken++;
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (!hold_done && beats_taken >= HOLD_AFTER) begin
        hold_done  = 1'b1;
        hold_left  = HOLD_CYCLES - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= !quiet && ($urandom_range(0, 99) < 18);
      end
    end
  end

  // Watchdog on a plain cycle count.
  initial begin
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("tb_accumulator_alu_with_abort_core: FAIL");
    $finish;
  end

  initial begin
    rst           <= 1'b1;
    req_valid     <= 1'b0;
    kind          <= OP_SETACC;
    operand_value <= '0;
    quiet         <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: aborts from reset state, wrap, underflow both ways, zero divisors
    offer_instr(OP_GT, 32'd0);
    offer_instr(OP_SUB, 32'd1);            // underflow from zero
    offer_instr(OP_RDIV, 32'd5);           // accumulator zero as divisor
    offer_instr(OP_RMOD, 32'd5);
    offer_instr(OP_SETACC, 32'hFFFF_FFFF);
    offer_instr(OP_ADD, 32'd2);            // wraps to one
    offer_instr(OP_RSUB, 32'd0);           // underflow, acc above operand
    offer_instr(OP_RSUB, 32'd1);
    offer_instr(OP_SETACC, 32'hFFFF_FFFF);
    offer_instr(OP_MUL, 32'hFFFF_FFFF);    // wraps to one
    offer_instr(OP_SETACC, 32'd100);
    offer_instr(OP_DIV, 32'd0);
    offer_instr(OP_MOD, 32'd0);
    offer_instr(OP_DIV, 32'd7);
    offer_instr(OP_RDIV, 32'd100);
    offer_instr(OP_MOD, 32'd5);
    offer_instr(OP_RMOD, 32'd10);
    offer_instr(OP_SETCOND, 32'h8000_0000);
    offer_instr(OP_AND, 32'd0);
    offer_instr(OP_OR, 32'd1);
    offer_instr(OP_XOR, 32'hFFFF_FFFF);
    offer_instr(OP_EQ, 32'd2);
    offer_instr(OP_NE, 32'd2);
    offer_instr(OP_LT, 32'd3);
    offer_instr(OP_GE, 32'd2);
    offer_instr(OP_LE, 32'd1);
    offer_instr(KIND_SPARE_LO, 32'd0);
    offer_instr(KIND_SPARE_HI, 32'hFFFF_FFFF);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == PAUSE_AT) drain_block();
      quiet <= (n >= QUIET_FROM && n < QUIET_TO);
      offer_instr(pick_kind(), pick_operand());
    end

    drain_block();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("tb_accumulator_alu_with_abort_core: PASS");
    end else begin
      $display("tb_accumulator_alu_with_abort_core: FAIL");
    end
    $finish;
  end

endmodule
